// ===== rtl/pfti_pkg.sv =====
package pfti_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int MAX_FEATURES = 16;
	localparam int PT_W         = $clog2(MAX_POINTS);
	localparam int FEAT_W       = $clog2(MAX_FEATURES);
	localparam int TABLE_DEPTH  = MAX_POINTS * MAX_FEATURES;
	localparam int BANK_DEPTH   = TABLE_DEPTH / 2;
	localparam int ROW_W        = $clog2(BANK_DEPTH);
	localparam int DATA_W       = 32;
	localparam int NP_W         = 7;
	localparam int ADDR_W       = 4;

	// result queue, depth is a power of two so pointers wrap naturally
	localparam int FIFO_DEPTH = 16;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = FPTR_W + 1;

	typedef enum logic [1:0] {
		REG_NUM_POINTS     = 2'd0,
		REG_MIN_VALUE      = 2'd1,
		REG_INTERVAL_SCALE = 2'd2
	} reg_idx_t;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	localparam logic BANK_EVEN = 1'b0;
	localparam logic BANK_ODD  = 1'b1;

	localparam logic [NP_W-1:0]          NP_RESET    = 7'd2;
	localparam logic [DATA_W-1:0]        MIN_RESET   = 32'h0000_0000;
	localparam logic [DATA_W-1:0]        SCALE_RESET = 32'h0001_0000;

	typedef struct packed {
		logic              we;
		logic              wbank;
		logic [ROW_W-1:0]  wrow;
		logic [DATA_W-1:0] wdata;
		logic [ROW_W-1:0]  rrow_even;
		logic [ROW_W-1:0]  rrow_odd;
	} tbl_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} res_t;

endpackage

// ===== rtl/pfti_table.sv =====
module pfti_table (
	input  logic                        clk,
	input  pfti_pkg::tbl_req_t          req,
	output logic [pfti_pkg::DATA_W-1:0] rd_even,
	output logic [pfti_pkg::DATA_W-1:0] rd_odd
);
	import pfti_pkg::*;

	// even points in one bank, odd points in the other: a segment's two
	// end points always come from different banks
	logic [DATA_W-1:0] even_mem [BANK_DEPTH];
	logic [DATA_W-1:0] odd_mem  [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we && req.wbank == BANK_EVEN) begin
			even_mem[req.wrow] <= req.wdata;
		end
		rd_even <= even_mem[req.rrow_even];
	end

	always_ff @(posedge clk) begin
		if (req.we && req.wbank == BANK_ODD) begin
			odd_mem[req.wrow] <= req.wdata;
		end
		rd_odd <= odd_mem[req.rrow_odd];
	end

endmodule

// ===== rtl/pfti_fifo.sv =====
module pfti_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfti_pkg::res_t push_data,
	output logic           out_valid,
	input  logic           out_stall,
	output pfti_pkg::res_t out_data
);
	import pfti_pkg::*;

	res_t              mem [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              pop;
	logic              full;

	assign pop       = out_valid && !out_stall;
	assign full      = (cnt_q == FCNT_W'(FIFO_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("result pushed into a full queue");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(full && wr_ptr_q == rd_ptr_q) || (!full && (wr_ptr_q - rd_ptr_q) == cnt_q[FPTR_W-1:0]))
		else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/per_feature_table_interpolator_unit.sv =====
// Per-feature piecewise-linear table interpolator. Load items (req_type 0)
// write one Q16.16 point of one feature's table; convert items (req_type 1)
// map the sample to p = (value - min_value) * interval_scale, pick segment
// floor(p) clamped to 0..num_points-2, and return the interpolated (or,
// outside the table, extrapolated) point, saturated to 32 bits with a flag.
// The block takes one item per clock while in_stall is low. A convert's
// result passes six pipeline stages (scale multiply, segment and table
// address, table read, two-part fraction multiply, partial product sum,
// final add and saturate) and a 16-entry result queue. in_stall rises
// only when 16 converts are outstanding, i.e. when the consumer holds
// out_stall long enough to fill the queue. Loads and converts go through
// the table at the same stage, so a convert always sees every load accepted
// before it. The table needs no clearing after reset; points must be loaded
// before they are used. Configuration writes must be made only while no item
// is in flight; the block itself does not enforce it.
module per_feature_table_interpolator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [pfti_pkg::FEAT_W-1:0]         feature_index,
	input  logic [pfti_pkg::PT_W-1:0]           point_index,
	input  logic signed [pfti_pkg::DATA_W-1:0]  value,
	// result item channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pfti_pkg::DATA_W-1:0]  converted_value,
	output logic                                saturated,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pfti_pkg::ADDR_W-1:0]         paddr,
	input  logic [pfti_pkg::DATA_W-1:0]         pwdata,
	output logic [pfti_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import pfti_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [NP_W-1:0]          np_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] scale_q;
	logic                     cfg_we;
	reg_idx_t                 cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q    <= NP_RESET;
			min_q   <= MIN_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NUM_POINTS:     np_q    <= pwdata[NP_W-1:0];
				REG_MIN_VALUE:      min_q   <= pwdata;
				REG_INTERVAL_SCALE: scale_q <= pwdata;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NUM_POINTS:     prdata = {{(DATA_W-NP_W){1'b0}}, np_q};
			REG_MIN_VALUE:      prdata = min_q;
			REG_INTERVAL_SCALE: prdata = scale_q;
			default:            prdata = '0;
		endcase
	end

	// point count clamped to 2..MAX_POINTS, last usable segment index
	logic [NP_W-1:0] np_eff;
	logic [PT_W-1:0] np_m2;

	always_comb begin
		if (np_q < NP_W'(2)) begin
			np_eff = NP_W'(2);
		end else if (np_q > NP_W'(MAX_POINTS)) begin
			np_eff = NP_W'(MAX_POINTS);
		end else begin
			np_eff = np_q;
		end
		np_m2 = PT_W'(np_eff - NP_W'(2));
	end

	// ------------------------------------------------------------------
	// input acceptance and credit count
	// ------------------------------------------------------------------
	// cred_q counts converts accepted and not yet delivered; it never
	// exceeds the queue depth, so the queue cannot overflow even when the
	// consumer stalls with the whole pipeline busy
	logic              in_acc;
	logic              out_acc;
	logic              cred_inc;
	logic [FCNT_W-1:0] cred_q;

	assign in_stall = (cred_q == FCNT_W'(FIFO_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign cred_inc = in_acc && (req_type == REQ_CONVERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else if (cred_inc && !out_acc) begin
			cred_q <= cred_q + 1'b1;
		end else if (out_acc && !cred_inc) begin
			cred_q <= cred_q - 1'b1;
		end
	end

	// range checks; a bad feature gives a zero result, a bad point a no-op
	logic feat_ok;
	logic pt_ok;
	logic signed [DATA_W:0] diff_in;

	assign feat_ok = ({1'b0, feature_index} < (FEAT_W+1)'(MAX_FEATURES));
	assign pt_ok   = ({1'b0, point_index} < (PT_W+1)'(MAX_POINTS));
	// exact 33-bit sample offset
	assign diff_in = {value[DATA_W-1], value} - {min_q[DATA_W-1], min_q};

	// ------------------------------------------------------------------
	// pipeline valid bits, the pipeline itself never stalls
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: item captured with its offset from min_value
	// ------------------------------------------------------------------
	logic                     cvt_s1, fok_s1, pok_s1;
	logic [FEAT_W-1:0]        feat_s1;
	logic [PT_W-1:0]          pt_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic signed [DATA_W:0]   diff_s1;

	always_ff @(posedge clk) begin
		cvt_s1  <= req_type;
		fok_s1  <= feat_ok;
		pok_s1  <= pt_ok;
		feat_s1 <= feature_index;
		pt_s1   <= point_index;
		val_s1  <= value;
		diff_s1 <= diff_in;
	end

	// ------------------------------------------------------------------
	// stage 2: Q32.32 position, held product of offset and scale
	// ------------------------------------------------------------------
	logic signed [2*DATA_W:0]   prod_full;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic                       cvt_s2, fok_s2, pok_s2;
	logic [FEAT_W-1:0]          feat_s2;
	logic [PT_W-1:0]            pt_s2;
	logic signed [DATA_W-1:0]   val_s2;

	// |offset| < 2^32 and |scale| <= 2^31, so the product fits in 64 bits
	assign prod_full = diff_s1 * scale_q;

	always_ff @(posedge clk) begin
		prod_s2 <= prod_full[2*DATA_W-1:0];
		cvt_s2  <= cvt_s1;
		fok_s2  <= fok_s1;
		pok_s2  <= pok_s1;
		feat_s2 <= feat_s1;
		pt_s2   <= pt_s1;
		val_s2  <= val_s1;
	end

	// segment pick, fraction, and table access for both item kinds
	logic [DATA_W-1:0]          pos_int;
	logic [PT_W-1:0]            seg;
	logic signed [2*DATA_W-1:0] frac;
	tbl_req_t                   tbl_req;
	logic [DATA_W-1:0]          rd_even, rd_odd;

	assign pos_int = prod_s2[2*DATA_W-1:DATA_W];

	always_comb begin
		if (prod_s2[2*DATA_W-1]) begin
			seg = '0;  // left of the table: extrapolate from the first segment
		end else if (pos_int > DATA_W'(np_m2)) begin
			seg = np_m2;  // right of the table: extrapolate from the last one
		end else begin
			seg = pos_int[PT_W-1:0];
		end
		frac = prod_s2 - $signed({{(DATA_W-PT_W){1'b0}}, seg, {DATA_W{1'b0}}});
	end

	// loads write in the same stage where converts read, keeping order
	always_comb begin
		tbl_req.we        = v_s2 && (cvt_s2 == REQ_LOAD) && fok_s2 && pok_s2;
		tbl_req.wbank     = pt_s2[0];
		tbl_req.wrow      = {feat_s2, pt_s2[PT_W-1:1]};
		tbl_req.wdata     = val_s2;
		// an odd segment starts in the odd bank, its end point is in the
		// next even row
		tbl_req.rrow_even = {feat_s2, seg[PT_W-1:1] + (PT_W-1)'(seg[0])};
		tbl_req.rrow_odd  = {feat_s2, seg[PT_W-1:1]};
	end

	pfti_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	// ------------------------------------------------------------------
	// stage 3: table data arrives, segment end points and slope
	// ------------------------------------------------------------------
	logic                       cvt_s3, fok_s3, seg0_s3;
	logic signed [2*DATA_W-1:0] frac_s3;
	logic signed [DATA_W-1:0]   d0, d1;
	logic signed [DATA_W:0]     delta;

	always_ff @(posedge clk) begin
		cvt_s3  <= cvt_s2;
		fok_s3  <= fok_s2;
		seg0_s3 <= seg[0];
		frac_s3 <= frac;
	end

	always_comb begin
		d0    = seg0_s3 ? rd_odd  : rd_even;
		d1    = seg0_s3 ? rd_even : rd_odd;
		delta = {d1[DATA_W-1], d1} - {d0[DATA_W-1], d0};
	end

	// ------------------------------------------------------------------
	// stage 4: fraction times slope, split at the binary point
	// ------------------------------------------------------------------
	logic                       cvt_s4, fok_s4;
	logic signed [DATA_W-1:0]   d0_s4;
	logic signed [DATA_W:0]     delta_s4;
	logic signed [2*DATA_W-1:0] frac_s4;
	logic signed [DATA_W-1:0]   frac_hi;
	logic signed [DATA_W:0]     frac_lo;
	logic signed [2*DATA_W:0]   ph;
	logic signed [2*DATA_W+1:0] pl;

	always_ff @(posedge clk) begin
		cvt_s4   <= cvt_s3;
		fok_s4   <= fok_s3;
		d0_s4    <= d0;
		delta_s4 <= delta;
		frac_s4  <= frac_s3;
	end

	// frac = hi * 2^32 + lo, hi signed and lo unsigned
	assign frac_hi = frac_s4[2*DATA_W-1:DATA_W];
	assign frac_lo = {1'b0, frac_s4[DATA_W-1:0]};
	assign ph      = frac_hi * delta_s4;
	assign pl      = frac_lo * delta_s4;

	// ------------------------------------------------------------------
	// stage 5: exact term, floored to Q16.16
	// ------------------------------------------------------------------
	logic                       cvt_s5, fok_s5;
	logic signed [DATA_W-1:0]   d0_s5;
	logic signed [2*DATA_W:0]   ph_s5;
	logic signed [2*DATA_W+1:0] pl_s5;
	logic signed [2*DATA_W+1:0] term;

	always_ff @(posedge clk) begin
		cvt_s5 <= cvt_s4;
		fok_s5 <= fok_s4;
		d0_s5  <= d0_s4;
		ph_s5  <= ph;
		pl_s5  <= pl;
	end

	// the arithmetic shift gives the floor of the low partial product
	assign term = ph_s5 + (pl_s5 >>> DATA_W);

	// ------------------------------------------------------------------
	// stage 6: add the segment start, saturate, push the result
	// ------------------------------------------------------------------
	logic                       cvt_s6, fok_s6;
	logic signed [DATA_W-1:0]   d0_s6;
	logic signed [2*DATA_W+1:0] term_s6;
	logic signed [2*DATA_W+2:0] sum;
	logic [DATA_W+3:0]          sum_hi;
	res_t                       res;
	logic                       push;
	res_t                       out_data;

	always_ff @(posedge clk) begin
		cvt_s6  <= cvt_s5;
		fok_s6  <= fok_s5;
		d0_s6   <= d0_s5;
		term_s6 <= term;
	end

	// a term too large to fit a 32-bit result simply drives the sum past
	// the range, so the one saturation check covers it
	assign sum    = {{(DATA_W+3){d0_s6[DATA_W-1]}}, d0_s6} + {term_s6[2*DATA_W+1], term_s6};
	assign sum_hi = sum[2*DATA_W+2:DATA_W-1];

	always_comb begin
		if (!fok_s6) begin
			res.value = '0;
			res.sat   = 1'b0;
		end else if ((&sum_hi) || !(|sum_hi)) begin
			res.value = sum[DATA_W-1:0];
			res.sat   = 1'b0;
		end else if (sum[2*DATA_W+2]) begin
			res.value = {1'b1, {(DATA_W-1){1'b0}}};
			res.sat   = 1'b1;
		end else begin
			res.value = {1'b0, {(DATA_W-1){1'b1}}};
			res.sat   = 1'b1;
		end
	end

	assign push = v_s6 && (cvt_s6 == REQ_CONVERT);

	pfti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign converted_value = out_data.value;
	assign saturated       = out_data.sat;

	a_cred_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= FCNT_W'(FIFO_DEPTH))
		else $error("outstanding convert count past queue depth");

	a_out_has_cred: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cred_q != '0))
		else $error("result offered with no convert outstanding");

	a_cvt_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cred_inc |=> (v_s1 && cvt_s1 == REQ_CONVERT))
		else $error("accepted convert missing from first stage");

endmodule
